### rtl/rsds_pkg.sv
// ============================================================================
// rsds_pkg - shared types and constants of the rotary slice display scheduler
// Field widths, command and action codes, and the command and status bundles
// that pass between the controller and the datapath.
// ============================================================================
package rsds_pkg;

   localparam int CMD_W       = 2;
   localparam int TIME_W      = 32;
   localparam int SLICE_SEL_W = 4;
   localparam int LED_SEL_W   = 5;
   localparam int COLOR_W     = 24;

   // Request command codes.
   localparam logic [CMD_W-1:0] CMD_POLL  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PULSE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

   // Response action codes.
   localparam logic ACT_SET   = 1'b0;
   localparam logic ACT_BLANK = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_write;     // write black at the clearing address and advance
      logic capture;       // latch the accepted request
      logic pulse_upd;     // take a new rotation period and pulse time
      logic pix_wr;        // write the pixel store if the address is in range
      logic mul_load;      // load the divider with elapsed * SLICES
      logic div_step;      // one restoring division step
      logic addr_load;     // point the read address at the first LED of the slice
      logic led_step;      // advance to the next LED
      logic emit_led;      // load the response register with one LED colour
      logic emit_blank;    // load the response register with a blank action
      logic commit_slice;  // record the new slice as shown
   } rsds_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic             clr_done;
      logic [CMD_W-1:0] cmd;
      logic             period_zero;
      logic             elapsed_ge;
      logic             slice_shown;
      logic             div_done;
      logic             slice_ok;
      logic             led_last;
      logic             out_free;
   } rsds_stat_type;

endpackage

### rtl/rsds_req_if.sv
// ============================================================================
// rsds_req_if - request channel of the rotary slice display scheduler
// Valid/ready channel carrying one command with its timestamp and pixel data.
// ============================================================================
interface rsds_req_if import rsds_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       cmd;
   logic [TIME_W-1:0]      now_ms;
   logic [SLICE_SEL_W-1:0] slice_sel;
   logic [LED_SEL_W-1:0]   led_sel;
   logic [COLOR_W-1:0]     pixel_color;

   modport source (
      output valid, cmd, now_ms, slice_sel, led_sel, pixel_color,
      input  ready
   );

   modport sink (
      input  valid, cmd, now_ms, slice_sel, led_sel, pixel_color,
      output ready
   );

endinterface

### rtl/rsds_rsp_if.sv
// ============================================================================
// rsds_rsp_if - response channel of the rotary slice display scheduler
// Valid/ready channel carrying one LED update or strip blank per transfer.
// ============================================================================
interface rsds_rsp_if import rsds_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [LED_SEL_W-1:0] led_index;
   logic [COLOR_W-1:0]   color;
   logic                 last;

   modport source (
      output valid, action, led_index, color, last,
      input  ready
   );

   modport sink (
      input  valid, action, led_index, color, last,
      output ready
   );

endinterface

### rtl/rsds_ctrl.sv
// ============================================================================
// rsds_ctrl - sequencing controller
// State machine that clears the pixel store after reset, accepts requests and
// steps the datapath through division and the LED read-out.
// ============================================================================
module rsds_ctrl import rsds_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  rsds_stat_type stat,
   output rsds_cmd_type  cmd_o
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DECODE = 4'd2;
   localparam logic [3:0] ST_MUL    = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_CHECK  = 4'd5;
   localparam logic [3:0] ST_READ   = 4'd6;
   localparam logic [3:0] ST_EMIT   = 4'd7;
   localparam logic [3:0] ST_BLANK  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd_o.clr_write = 1'b1;
            if (stat.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.capture = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            unique case (stat.cmd)
               CMD_POLL: begin
                  if (!stat.period_zero) begin
                     if (stat.elapsed_ge) begin
                        if (stat.slice_shown) begin
                           state_in = ST_BLANK;
                        end
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
               end
               CMD_PULSE: cmd_o.pulse_upd = 1'b1;
               CMD_WRITE: cmd_o.pix_wr = 1'b1;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_MUL: begin
            cmd_o.mul_load = 1'b1;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            cmd_o.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.slice_ok) begin
               cmd_o.addr_load = 1'b1;
               state_in        = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd_o.emit_led = 1'b1;
               if (stat.led_last) begin
                  cmd_o.commit_slice = 1'b1;
                  state_in           = ST_IDLE;
               end else begin
                  cmd_o.led_step = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         ST_BLANK: begin
            if (stat.out_free) begin
               cmd_o.emit_blank = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/rsds_datapath.sv
// ============================================================================
// rsds_datapath - timing, division, pixel store and response register
// Holds the rotation state, a restoring divider, the polar pixel store
// and the registered response stage.
// ============================================================================
module rsds_datapath import rsds_pkg::*; #(
   parameter int SLICES = 12,
   parameter int LEDS   = 29
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsds_cmd_type           cmd_i,
   output rsds_stat_type          stat,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic [SLICE_SEL_W-1:0] req_slice_sel,
   input  logic [LED_SEL_W-1:0]   req_led_sel,
   input  logic [COLOR_W-1:0]     req_pixel_color,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_action,
   output logic [LED_SEL_W-1:0]   rsp_led_index,
   output logic [COLOR_W-1:0]     rsp_color,
   output logic                   rsp_last
);

   localparam int DEPTH = SLICES * LEDS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = $clog2(SLICES);
   localparam int LW    = (LEDS > 1) ? $clog2(LEDS) : 1;
   localparam logic [TIME_W-1:0] SLICES_T = TIME_W'(SLICES);
   localparam logic [6:0]        SLICES_V = 7'(SLICES);
   localparam logic [6:0]        LEDS_V   = 7'(LEDS);
   localparam logic [AW-1:0]     LEDS_A   = AW'(LEDS);
   localparam logic [AW-1:0]     LAST_A   = AW'(DEPTH - 1);
   localparam logic [LW-1:0]     LAST_L   = LW'(LEDS - 1);

   // Captured request.
   logic [CMD_W-1:0]       cmd_ff;
   logic [TIME_W-1:0]      now_ff;
   logic [SLICE_SEL_W-1:0] slice_sel_ff;
   logic [LED_SEL_W-1:0]   led_sel_ff;
   logic [COLOR_W-1:0]     color_ff;

   // Rotation state.
   logic [TIME_W-1:0] pulse_time_ff;
   logic [TIME_W-1:0] period_ff;
   logic [SW-1:0]     shown_slice_ff;
   logic              shown_ff;

   // Divider.
   logic [TIME_W-1:0] elapsed_ff;
   logic [TIME_W-1:0] elapsed_in;
   logic [TIME_W-1:0] div_n_ff;
   logic [TIME_W-1:0] div_r_ff;
   logic [4:0]        div_cnt_ff;
   logic [TIME_W:0]   div_shift;
   logic [TIME_W:0]   div_diff;

   // Pixel store.
   logic [COLOR_W-1:0] store [DEPTH];
   logic [COLOR_W-1:0] mem_q_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic [AW-1:0]      rd_addr_ff;
   logic [LW-1:0]      led_cnt_ff;
   logic [AW-1:0]      pix_addr;
   logic               pix_in_range;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [COLOR_W-1:0] wr_data;

   // Response register.
   logic                 rsp_valid_ff;
   logic                 rsp_action_ff;
   logic [LED_SEL_W-1:0] rsp_led_index_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic                 rsp_last_ff;

   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         cmd_ff       <= req_cmd;
         now_ff       <= req_now_ms;
         slice_sel_ff <= req_slice_sel;
         led_sel_ff   <= req_led_sel;
         color_ff     <= req_pixel_color;
      end
   end

   assign elapsed_in = now_ff - pulse_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_time_ff  <= '0;
         period_ff      <= '0;
         shown_slice_ff <= '0;
         shown_ff       <= 1'b0;
      end else begin
         if (cmd_i.pulse_upd) begin
            period_ff     <= elapsed_in;
            pulse_time_ff <= now_ff;
         end
         if (cmd_i.commit_slice) begin
            shown_slice_ff <= div_n_ff[SW-1:0];
            shown_ff       <= 1'b1;
         end else if (cmd_i.emit_blank) begin
            shown_ff <= 1'b0;
         end
      end
   end

   // Restoring division: the quotient shifts into the dividend register.
   assign div_shift = {div_r_ff, div_n_ff[TIME_W-1]};
   assign div_diff  = div_shift - {1'b0, period_ff};

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      if (cmd_i.mul_load) begin
         div_n_ff   <= elapsed_ff * SLICES_T;
         div_r_ff   <= '0;
         div_cnt_ff <= '0;
      end else if (cmd_i.div_step) begin
         div_cnt_ff <= div_cnt_ff + 5'd1;
         if (!div_diff[TIME_W]) begin
            div_r_ff <= div_diff[TIME_W-1:0];
            div_n_ff <= {div_n_ff[TIME_W-2:0], 1'b1};
         end else begin
            div_r_ff <= div_shift[TIME_W-1:0];
            div_n_ff <= {div_n_ff[TIME_W-2:0], 1'b0};
         end
      end
   end

   // Pixel store write port, shared by the clearing pass and pixel writes.
   assign pix_in_range = ({3'b000, slice_sel_ff} < SLICES_V) && ({2'b00, led_sel_ff} < LEDS_V);
   assign pix_addr     = AW'(slice_sel_ff) * LEDS_A + AW'(led_sel_ff);
   assign wr_en        = cmd_i.clr_write || (cmd_i.pix_wr && pix_in_range);
   assign wr_addr      = cmd_i.clr_write ? clr_addr_ff : pix_addr;
   assign wr_data      = cmd_i.clr_write ? '0 : color_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      mem_q_ff <= store[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd_i.clr_write) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.addr_load) begin
         rd_addr_ff <= AW'(div_n_ff[SW-1:0]) * LEDS_A;
         led_cnt_ff <= '0;
      end else if (cmd_i.led_step) begin
         rd_addr_ff <= rd_addr_ff + AW'(1);
         led_cnt_ff <= led_cnt_ff + LW'(1);
      end
   end

   // Response register: a new response may load while the old one leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.emit_led || cmd_i.emit_blank) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.emit_led) begin
         rsp_action_ff    <= ACT_SET;
         rsp_led_index_ff <= LED_SEL_W'(led_cnt_ff);
         rsp_color_ff     <= mem_q_ff;
         rsp_last_ff      <= (led_cnt_ff == LAST_L);
      end else if (cmd_i.emit_blank) begin
         rsp_action_ff    <= ACT_BLANK;
         rsp_led_index_ff <= '0;
         rsp_color_ff     <= '0;
         rsp_last_ff      <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = rsp_action_ff;
   assign rsp_led_index = rsp_led_index_ff;
   assign rsp_color     = rsp_color_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      stat.clr_done    = (clr_addr_ff == LAST_A);
      stat.cmd         = cmd_ff;
      stat.period_zero = (period_ff == '0);
      stat.elapsed_ge  = (elapsed_in >= period_ff);
      stat.slice_shown = shown_ff;
      stat.div_done    = (div_cnt_ff == 5'd31);
      stat.slice_ok    = (div_n_ff < SLICES_T) &&
                         !(shown_ff && (div_n_ff == TIME_W'(shown_slice_ff)));
      stat.led_last    = (led_cnt_ff == LAST_L);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

### rtl/rotary_slice_display_scheduler_top.sv
// ============================================================================
// rotary_slice_display_scheduler_top - persistence-of-vision slice scheduler
// Drives the LED strip of a spinning display from a polar pixel store.
// ============================================================================
// Usage. Requests arrive on req_chan: a time poll, a hall sensor pulse or a
// pixel write. A pulse records the time since the previous pulse as the
// rotation period. A poll works out the angular slice now due and, when it
// differs from the slice on show, sends one response per LED on rsp_chan with
// last set on the final LED. A poll made after a whole period without a pulse
// sends a single blank response, once. Pulses and pixel writes give nothing.
// Timing. One request is handled at a time. A pulse, a pixel write or a poll
// stopped by a zero period or an idle strip ends once decoded; a blanking poll
// then loads the blank response; a poll whose slice is on show or out of range
// ends after the bit-serial divider. A slice change runs the divider, then a
// pixel store read and a response load for each LED.
// Reset. The synchronous reset clears the rotation state and then sweeps the
// pixel store to black, one entry a cycle across all SLICES*LEDS entries,
// during which req_chan.ready stays low.
// Stalls. Responses leave through a register; while rsp_chan.ready is low
// the LED read-out waits, and a finished request does not hold up the next.
// ============================================================================
module rotary_slice_display_scheduler_top import rsds_pkg::*; #(
   parameter int SLICES = 12,
   parameter int LEDS   = 29
) (
   input  logic      clock,
   input  logic      reset,
   rsds_req_if.sink  req_chan,
   rsds_rsp_if.source rsp_chan
);

   rsds_cmd_type  ctrl_cmd;
   rsds_stat_type dp_stat;

   // The controller sequences each request; it alone decides when to accept.
   rsds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (dp_stat),
      .cmd_o     (ctrl_cmd)
   );

   // The datapath holds the timing state, the divider, the pixel store and
   // the response register.
   rsds_datapath #(
      .SLICES (SLICES),
      .LEDS   (LEDS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd_i           (ctrl_cmd),
      .stat            (dp_stat),
      .req_cmd         (req_chan.cmd),
      .req_now_ms      (req_chan.now_ms),
      .req_slice_sel   (req_chan.slice_sel),
      .req_led_sel     (req_chan.led_sel),
      .req_pixel_color (req_chan.pixel_color),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_action      (rsp_chan.action),
      .rsp_led_index   (rsp_chan.led_index),
      .rsp_color       (rsp_chan.color),
      .rsp_last        (rsp_chan.last)
   );

endmodule
